// File: design/ccpc_pkg.sv
// Shared types and constants for the corridor clear path check.
package ccpc_pkg;
  localparam int POS_W  = 20;
  localparam int DIF_W  = 21;
  localparam int CRN_W  = 22;
  localparam int MRG_W  = 16;
  localparam int ID_W   = 32;
  localparam int L2_W   = 41;
  localparam int LEN_W  = 21;
  localparam int NUM_W  = 37;
  localparam int DOT_W  = 47;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic OP_QUERY    = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  // One request as it travels from the front part to the back part.
  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic                    skip;
    logic                    last;
  } req_t;
endpackage

// File: design/ccpc_front.sv
// Front part: accepts requests, marks self neighbors and queues them.
module ccpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_goal_x,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_goal_y,
  input  logic [ccpc_pkg::ID_W-1:0]     in_neighbor_id,
  input  logic                          in_last,
  input  logic [ccpc_pkg::ID_W-1:0]     self_id,
  output logic                          q_valid,
  output ccpc_pkg::req_t                q_req,
  input  logic                          q_take
);
  import ccpc_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  req_t       w;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    w.op     = in_op;
    w.pos_x  = in_pos_x;
    w.pos_y  = in_pos_y;
    w.goal_x = in_goal_x;
    w.goal_y = in_goal_y;
    w.skip   = (in_op == OP_NEIGHBOR) && (in_neighbor_id == self_id);
    w.last   = in_last;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= w;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

// File: design/ccpc_divsqrt.sv
// Iterative square root and rounded divide for the corridor direction.
module ccpc_divsqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ccpc_pkg::L2_W-1:0]         l2,
  input  logic signed [ccpc_pkg::NUM_W-1:0] num_x,
  input  logic signed [ccpc_pkg::NUM_W-1:0] num_y,
  output logic                              done,
  output logic signed [ccpc_pkg::CRN_W-1:0] vx,
  output logic signed [ccpc_pkg::CRN_W-1:0] vy
);
  import ccpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SQRT = 4'b0010, S_DIV = 4'b0100, S_DONE = 4'b1000
  } st_t;

  localparam int QW = NUM_W + 1;

  st_t              st_r, st_nxt;
  logic [L2_W+1:0]  rem_r;     // sqrt remainder
  logic [LEN_W-1:0] root_r;
  logic [5:0]       cnt_r;
  logic [QW:0]      dr_r [2];  // divide remainders
  logic [QW-1:0]    dn_r [2];  // dividends shifting out
  logic [QW-1:0]    qt_r [2];
  logic             neg_r [2];
  logic [QW:0]      den2;
  logic [QW:0]      dsh [2];
  logic [QW-1:0]    mag [2];
  logic [QW-1:0]    qs  [2];
  logic [L2_W+1:0]  sq_rem_sh;
  logic [L2_W+1:0]  sq_try;
  logic [L2_W:0]    l2_r;
  logic             sq_bit;

  always_comb begin
    mag[0] = num_x[NUM_W-1] ? QW'(-num_x) : QW'(num_x);
    mag[1] = num_y[NUM_W-1] ? QW'(-num_y) : QW'(num_y);
    den2   = (QW+1)'({root_r, 1'b0});
    for (int i = 0; i < 2; i++) dsh[i] = {dr_r[i][QW-1:0], dn_r[i][QW-1]};
  end

  // Digit-by-digit square root, two bits of l2 per step.
  always_comb begin
    sq_rem_sh = {rem_r[L2_W-1:0], l2_r[L2_W -: 2]};
    sq_try    = (L2_W+2)'({root_r, 2'b01});
    sq_bit    = (sq_rem_sh >= sq_try);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 6'd0) st_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd0) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        l2_r   <= {1'b0, l2};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 6'(LEN_W - 1);
        for (int i = 0; i < 2; i++) begin
          // 2*mag + len, divided by 2*len: append len after the sqrt.
          dn_r[i] <= mag[i];
          neg_r[i] <= (i == 0) ? num_x[NUM_W-1] : num_y[NUM_W-1];
        end
      end
      S_SQRT: begin
        l2_r <= {l2_r[L2_W-2:0], 2'b00};
        if (sq_bit) begin
          rem_r  <= sq_rem_sh - sq_try;
          root_r <= {root_r[LEN_W-2:0], 1'b1};
        end else begin
          rem_r  <= sq_rem_sh;
          root_r <= {root_r[LEN_W-2:0], 1'b0};
        end
        cnt_r <= (cnt_r == 6'd0) ? 6'(QW - 1) : cnt_r - 6'd1;
        // The dividend 2*mag + len is formed at the sqrt-to-divide switch.
        if (cnt_r == 6'd0) begin
          for (int i = 0; i < 2; i++) begin
            dr_r[i] <= '0;
            qt_r[i] <= '0;
            dn_r[i] <= {dn_r[i][QW-2:0], 1'b0} + QW'({root_r[LEN_W-2:0], sq_bit});
          end
        end
      end
      S_DIV: begin
        for (int i = 0; i < 2; i++) begin
          if (dsh[i] >= den2) begin
            dr_r[i] <= dsh[i] - den2;
            qt_r[i] <= {qt_r[i][QW-2:0], 1'b1};
          end else begin
            dr_r[i] <= dsh[i];
            qt_r[i] <= {qt_r[i][QW-2:0], 1'b0};
          end
          dn_r[i] <= {dn_r[i][QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      S_DONE: ;
      default: ;
    endcase
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    for (int i = 0; i < 2; i++) qs[i] = neg_r[i] ? -qt_r[i] : qt_r[i];
  end

  assign done = (st_r == S_DONE);
  assign vx   = CRN_W'(qs[0]);
  assign vy   = CRN_W'(qs[1]);
endmodule

// File: design/ccpc_back.sv
// Back part: builds the corridor and tests neighbors against it.
module ccpc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ccpc_pkg::req_t                q_req,
  output logic                          q_take,
  input  logic [ccpc_pkg::MRG_W-1:0]    margin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_clear
);
  import ccpc_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001, B_MUL = 7'b0000010, B_DIV = 7'b0000100,
    B_CRN  = 7'b0001000, B_T1  = 7'b0010000, B_T2 = 7'b0100000,
    B_FIN  = 7'b1000000
  } bst_t;

  bst_t st_r, st_nxt;
  logic signed [CRN_W-1:0] ax_r, ay_r, bx_r, by_r, dx_c_r, dy_c_r;
  logic signed [CRN_W-1:0] abx_r, aby_r, adx_r, ady_r;
  logic degen_r, blocked_r;
  req_t cur_r;
  logic signed [DIF_W-1:0] ddx_r, ddy_r;
  logic [L2_W-1:0] l2_r;
  logic signed [L2_W-1:0] sqx, sqy;
  logic [L2_W-1:0] l2_c;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic ov_r, oc_r;
  logic div_start, div_done;
  logic signed [CRN_W-1:0] vx, vy, vx_u, vy_u;
  logic signed [DOT_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic in_r;
  logic signed [CRN_W:0] amx, amy, bmx, bmy, dmx, dmy;
  logic signed [DOT_W-1:0] d1, d2, d3, d4;
  logic room;

  assign room   = !ov_r || !out_stall;
  assign q_take = (st_r == B_IDLE) && q_valid;

  assign amx = (CRN_W+1)'(cur_r.pos_x) - (CRN_W+1)'(ax_r);
  assign amy = (CRN_W+1)'(cur_r.pos_y) - (CRN_W+1)'(ay_r);
  assign bmx = (CRN_W+1)'(cur_r.pos_x) - (CRN_W+1)'(bx_r);
  assign bmy = (CRN_W+1)'(cur_r.pos_y) - (CRN_W+1)'(by_r);
  assign dmx = (CRN_W+1)'(cur_r.pos_x) - (CRN_W+1)'(dx_c_r);
  assign dmy = (CRN_W+1)'(cur_r.pos_y) - (CRN_W+1)'(dy_c_r);

  assign d1 = p0_r + p1_r;
  assign d2 = p2_r + p3_r;
  assign d3 = p4_r + p5_r;
  assign d4 = p6_r + p7_r;

  assign sqx  = L2_W'(ddx_r) * L2_W'(ddx_r);
  assign sqy  = L2_W'(ddy_r) * L2_W'(ddy_r);
  assign l2_c = $unsigned(sqx) + $unsigned(sqy);

  // The divider starts on the first cycle of B_DIV, once l2 and the numerators are held, unless l2 is zero.
  assign div_start = (st_r == B_DIV) && !degen_r;
  assign vx_u = degen_r ? '0 : vx;
  assign vy_u = degen_r ? '0 : vy;

  ccpc_divsqrt u_ds (
    .clk(clk), .rst_n(rst_n), .start(div_start), .l2(l2_r),
    .num_x(nx_r), .num_y(ny_r), .done(div_done), .vx(vx), .vy(vy)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (q_valid)
        st_nxt = (q_req.op == OP_QUERY) ? B_MUL : (q_req.skip ? B_FIN : B_T1);
      B_MUL: st_nxt = B_DIV;
      B_DIV: if (degen_r || div_done) st_nxt = B_CRN;
      B_CRN: st_nxt = B_FIN;
      B_T1:  st_nxt = B_T2;
      B_T2:  st_nxt = B_FIN;
      B_FIN: if (!cur_r.last || room) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && q_valid) begin
      cur_r <= q_req;
      ddx_r <= DIF_W'(q_req.goal_x) - DIF_W'(q_req.pos_x);
      ddy_r <= DIF_W'(q_req.goal_y) - DIF_W'(q_req.pos_y);
    end
    if (st_r == B_MUL) begin
      l2_r <= l2_c;
      nx_r <= NUM_W'($signed({1'b0, margin})) * NUM_W'(ddx_r);
      ny_r <= NUM_W'($signed({1'b0, margin})) * NUM_W'(ddy_r);
    end
    if (st_r == B_T1) begin
      p0_r <= abx_r * amx; p1_r <= aby_r * amy;
      p2_r <= adx_r * amx; p3_r <= ady_r * amy;
      p4_r <= abx_r * bmx; p5_r <= aby_r * bmy;
      p6_r <= adx_r * dmx; p7_r <= ady_r * dmy;
    end
    if (st_r == B_T2)
      in_r <= degen_r || (d1 >= 0 && d2 >= 0 && d3 <= 0 && d4 <= 0);
    if (!rst_n) begin
      st_r <= B_IDLE;
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0;
      dx_c_r <= '0; dy_c_r <= '0;
      abx_r <= '0; aby_r <= '0; adx_r <= '0; ady_r <= '0;
      degen_r <= 1'b0; blocked_r <= 1'b0; ov_r <= 1'b0; oc_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_MUL) degen_r <= (l2_c == '0);
      if (st_r == B_CRN) begin
        ax_r   <= CRN_W'(cur_r.pos_x) - vy_u;
        ay_r   <= CRN_W'(cur_r.pos_y) + vx_u;
        bx_r   <= CRN_W'(cur_r.pos_x) + vy_u;
        by_r   <= CRN_W'(cur_r.pos_y) - vx_u;
        dx_c_r <= CRN_W'(cur_r.pos_x) - vy_u + vx_u + CRN_W'(ddx_r);
        dy_c_r <= CRN_W'(cur_r.pos_y) + vx_u + vy_u + CRN_W'(ddy_r);
        abx_r  <= CRN_W'(2) * vy_u;
        aby_r  <= -(CRN_W'(2) * vx_u);
        adx_r  <= vx_u + CRN_W'(ddx_r);
        ady_r  <= vy_u + CRN_W'(ddy_r);
        blocked_r <= 1'b0;
      end
      if (ov_r && !out_stall && !(st_r == B_FIN && cur_r.last)) ov_r <= 1'b0;
      if (st_r == B_FIN && (!cur_r.last || room)) begin
        logic blk;
        blk = blocked_r ||
              (cur_r.op == OP_NEIGHBOR && !cur_r.skip && in_r);
        if (cur_r.last) begin
          ov_r <= 1'b1;
          oc_r <= !blk;
          blocked_r <= 1'b0;
        end else begin
          blocked_r <= blk;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_clear = oc_r;
endmodule

// File: design/corridor_clear_path_check.sv
// Top level of the corridor clear path check.
//
//  channel | handshake         | payload
//  in_     | in_valid/in_stall | op, pos_x/y, goal_x/y, neighbor_id, last
//  out_    | out_valid/out_stall | clear
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A neighbor request passes the take, multiply, compare and finish states in the back
// part; a self neighbor passes take and finish only. A query request waits on the
// bit-serial square root (21 steps) and divide (38 steps); current equal to goal skips them.
// A two-entry queue parts front and back. The result is registered.
// Reset is synchronous; it clears the corridor to zero and margin to 3200.
// out_stall holds the result register; the back part waits only on a last request.
module corridor_clear_path_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_goal_x,
  input  logic signed [ccpc_pkg::POS_W-1:0] in_goal_y,
  input  logic [ccpc_pkg::ID_W-1:0]         in_neighbor_id,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_clear,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [ccpc_pkg::ID_W-1:0]         cfg_data
);
  import ccpc_pkg::*;

  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_SELF   = 1'b1;

  logic [MRG_W-1:0] margin_r;
  logic [ID_W-1:0]  self_r;
  logic             q_valid, q_take;
  req_t             q_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MRG_W'(3200);
      self_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MARGIN: margin_r <= cfg_data[MRG_W-1:0];
        REG_SELF:   self_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  ccpc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_goal_x(in_goal_x), .in_goal_y(in_goal_y),
    .in_neighbor_id(in_neighbor_id), .in_last(in_last), .self_id(self_r),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  ccpc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
    .q_take(q_take), .margin(margin_r), .out_valid(out_valid),
    .out_stall(out_stall), .out_clear(out_clear)
  );
endmodule
